// ===== hw/rtl/refcounted_id_registry_core_defines.svh =====
// assertion macros for the id registry core
`ifndef REFCOUNTED_ID_REGISTRY_CORE_DEFINES_SVH
`define REFCOUNTED_ID_REGISTRY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, muted while reset is high
`define RCIDR_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rcidr assertion failed");
// checked property, live in every cycle
`define RCIDR_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rcidr assertion failed");
`else
`define RCIDR_ASSERT_RST(label, clk, rst, prop)
`define RCIDR_ASSERT(label, clk, prop)
`endif

`endif

// ===== hw/rtl/rcidr_pkg.sv =====
`default_nettype none

package rcidr_pkg;

   // table geometry
   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int HELD_W     = $clog2(ENTRIES + 1);

   // fixed field widths
   localparam int ID_W     = 32;
   localparam int OP_W     = 2;
   localparam int POS_W    = 5;
   localparam int REF_W    = 16;
   localparam int ITEMS_W  = 5;
   localparam int STATUS_W = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP     = 2'd0,
      OP_REGISTER   = 2'd1,
      OP_UNREGISTER = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_MISSING   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_SATURATED = 3'd3,
      STATUS_REMOVED   = 3'd4
   } status_type;

   // per-cell update controls from the sequencer
   typedef struct packed {
      logic load_prev;
      logic load_next;
      logic inc;
      logic dec;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rcidr_if.sv =====
`default_nettype none

// request channel
interface rcidr_req_if import rcidr_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] opcode;
   logic [ID_W-1:0] id;

   modport source (output valid, output opcode, output id, input ready);
   modport sink (input valid, input opcode, input id, output ready);
endinterface

// response channel
interface rcidr_rsp_if import rcidr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [POS_W-1:0]    position;
   logic [REF_W-1:0]    ref_count;
   logic [ITEMS_W-1:0]  item_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output found, output position, output ref_count,
                   output item_count, output status, input ready);
   modport sink (input valid, input found, input position, input ref_count,
                 input item_count, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/refcounted_id_registry_core.sv =====
// sequencing: a taken request moves the sequencer from idle to apply, and the response
//    register loads when the apply state fires, which waits while an earlier response is stalled
// requests: taken one at a time, the compare step on the taken request followed by the
//    update step of the cell row; a stalled response holds the update step
// reset: synchronous, clears the entry count and the handshake state; cell contents
//    stay undefined and are never read before being written, so there is no clearing pass
`default_nettype none

`include "refcounted_id_registry_core_defines.svh"

module refcounted_id_registry_core import rcidr_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   rcidr_req_if.sink   req_bus,
   rcidr_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [ID_W-1:0]   key_ff, key_in;
   op_type            op_ff, op_in;
   logic [HELD_W-1:0] held_ff, held_in;

   logic req_fire, apply_fire;

   // cell row wiring
   logic [ID_W-1:0]       id_vec [ENTRIES];
   logic [COUNT_BITS-1:0] count_vec [ENTRIES];
   logic [ENTRIES-1:0]    hit_vec;
   cell_ctrl_type         ctrl_vec [ENTRIES];

   // decoded update
   logic                  hit_any, full;
   logic [IDX_W-1:0]      slot;
   logic [COUNT_BITS-1:0] sel_count, rsp_count_val;
   logic [HELD_W-1:0]     pos_val;
   status_type            status_val;
   logic                  do_insert, do_remove, do_inc, do_dec;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff;
   logic [POS_W-1:0]    position_ff;
   logic [REF_W-1:0]    ref_count_ff;
   logic [ITEMS_W-1:0]  item_count_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [31:0]         pos_wide, count_wide, items_wide;

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign key_in = req_fire ? req_bus.id : key_ff;
   assign op_in  = req_fire ? op_type'(req_bus.opcode) : op_ff;

   // the row of cells, newest entry in cell zero
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);
      logic [ID_W-1:0]       prev_id, next_id;
      logic [COUNT_BITS-1:0] prev_count, next_count;
      logic                  occupied;

      if (i == 0) begin : g_head
         assign prev_id    = key_ff;
         assign prev_count = COUNT_ONE;
      end else begin : g_body
         assign prev_id    = id_vec[i-1];
         assign prev_count = count_vec[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign next_id    = id_vec[i];
         assign next_count = count_vec[i];
      end else begin : g_inner
         assign next_id    = id_vec[i+1];
         assign next_count = count_vec[i+1];
      end

      assign occupied = (HELD_W'(i) < held_ff);

      assign ctrl_vec[i].load_prev = apply_fire && do_insert;
      assign ctrl_vec[i].load_next = apply_fire && do_remove && (CELL_IDX >= slot);
      assign ctrl_vec[i].inc       = apply_fire && do_inc && hit_vec[i];
      assign ctrl_vec[i].dec       = apply_fire && do_dec && hit_vec[i];

      rcidr_cell u_cell (
         .clock      (clock),
         .compare_en (req_fire),
         .key        (req_bus.id),
         .occupied   (occupied),
         .ctrl       (ctrl_vec[i]),
         .prev_id    (prev_id),
         .prev_count (prev_count),
         .next_id    (next_id),
         .next_count (next_count),
         .id         (id_vec[i]),
         .count      (count_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // ids are unique, so at most one cell hits: encode its place and count
   always_comb begin
      sel_count = '0;
      slot      = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec[i]) begin
            sel_count = sel_count | count_vec[i];
            slot      = slot | IDX_W'(i);
         end
      end
   end

   assign hit_any = |hit_vec;
   assign full    = (held_ff == HELD_W'(ENTRIES));
   assign pos_val = hit_any ? HELD_W'(slot) : held_ff;

   // operation decode
   always_comb begin
      rsp_count_val = '0;
      status_val    = STATUS_OK;
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      do_inc        = 1'b0;
      do_dec        = 1'b0;
      held_in       = held_ff;
      case (op_ff)
         OP_LOOKUP: begin
            if (hit_any) rsp_count_val = sel_count;
            else status_val = STATUS_MISSING;
         end
         OP_REGISTER: begin
            if (hit_any) begin
               if (sel_count == COUNT_MAX) begin
                  rsp_count_val = COUNT_MAX;
                  status_val    = STATUS_SATURATED;
               end else begin
                  rsp_count_val = sel_count + COUNT_ONE;
                  do_inc        = 1'b1;
               end
            end else if (full) begin
               status_val = STATUS_FULL;
            end else begin
               rsp_count_val = COUNT_ONE;
               do_insert     = 1'b1;
               held_in       = held_ff + HELD_W'(1);
            end
         end
         OP_UNREGISTER: begin
            if (!hit_any) begin
               status_val = STATUS_MISSING;
            end else if (sel_count > COUNT_ONE) begin
               rsp_count_val = sel_count - COUNT_ONE;
               do_dec        = 1'b1;
            end else begin
               status_val = STATUS_REMOVED;
               do_remove  = 1'b1;
               held_in    = held_ff - HELD_W'(1);
            end
         end
         OP_CLEAR: begin
            held_in = '0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   // fit internal widths to the response fields
   assign pos_wide   = 32'(pos_val);
   assign count_wide = 32'(rsp_count_val);
   assign items_wide = 32'(held_in);

   assign rsp_valid_in = apply_fire || (rsp_valid_ff && !rsp_bus.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= apply_fire ? held_in : held_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      op_ff  <= op_in;
      if (apply_fire) begin
         found_ff      <= hit_any;
         position_ff   <= pos_wide[POS_W-1:0];
         ref_count_ff  <= count_wide[REF_W-1:0];
         item_count_ff <= items_wide[ITEMS_W-1:0];
         status_ff     <= status_val;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = found_ff;
   assign rsp_bus.position   = position_ff;
   assign rsp_bus.ref_count  = ref_count_ff;
   assign rsp_bus.item_count = item_count_ff;
   assign rsp_bus.status     = status_ff;

   // checks
   `RCIDR_ASSERT_RST(a_single_hit, clock, reset, (state_ff == ST_APPLY) |-> $onehot0(hit_vec))
   `RCIDR_ASSERT_RST(a_held_bound, clock, reset, held_ff <= HELD_W'(ENTRIES))
   `RCIDR_ASSERT_RST(a_insert_grows, clock, reset,
      (!reset && apply_fire && do_insert) |=> (held_ff == $past(held_ff) + HELD_W'(1)))
   `RCIDR_ASSERT_RST(a_apply_loads_rsp, clock, reset,
      (!reset && apply_fire) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))

endmodule

`default_nettype wire

// ===== hw/rtl/rcidr_cell.sv =====
`default_nettype none

module rcidr_cell import rcidr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  compare_en,
   input  wire logic [ID_W-1:0]       key,
   input  wire logic                  occupied,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [ID_W-1:0]       prev_id,
   input  wire logic [COUNT_BITS-1:0] prev_count,
   input  wire logic [ID_W-1:0]       next_id,
   input  wire logic [COUNT_BITS-1:0] next_count,
   output logic [ID_W-1:0]            id,
   output logic [COUNT_BITS-1:0]      count,
   output logic                       hit
);

   logic [ID_W-1:0]       id_ff, id_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  hit_ff, hit_in;

   // match flag, captured when a transaction is taken
   assign hit_in = compare_en ? (occupied && (id_ff == key)) : hit_ff;

   // shift from a neighbor or adjust the local count
   always_comb begin
      id_in    = id_ff;
      count_in = count_ff;
      if (ctrl.load_prev) begin
         id_in    = prev_id;
         count_in = prev_count;
      end else if (ctrl.load_next) begin
         id_in    = next_id;
         count_in = next_count;
      end else if (ctrl.inc) begin
         count_in = count_ff + COUNT_ONE;
      end else if (ctrl.dec) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      count_ff <= count_in;
      hit_ff   <= hit_in;
   end

   assign id    = id_ff;
   assign count = count_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire

// ===== verif/registry_reply_checker.sv =====
// watches both channels, predicts every reply of the id registry and compares it
module registry_reply_checker import rcidr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   rcidr_req_if     req_mon,
   rcidr_rsp_if     rsp_mon,
   output int       mismatches,
   output int       outstanding,
   output int       replies_checked,
   output int       full_seen,
   output int       saturated_seen,
   output int       removed_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                found;
      logic [POS_W-1:0]    position;
      logic [REF_W-1:0]    ref_count;
      logic [ITEMS_W-1:0]  item_count;
      status_type          status;
   } reply_type;

   // shadow copy of the table, newest entry at index 0
   logic [ID_W-1:0]       shadow_id [ENTRIES];
   logic [COUNT_BITS-1:0] shadow_count [ENTRIES];
   int                    shadow_held;

   reply_type awaited_replies[$];

   // apply one request to the shadow table and return the reply it must produce
   function automatic reply_type apply_request(op_type op, logic [ID_W-1:0] id);
      int                    slot;
      logic                  hit;
      logic [COUNT_BITS-1:0] cnt;
      status_type            st;
      reply_type             r;
      slot = shadow_held;
      for (int i = shadow_held - 1; i >= 0; i--) begin
         if (shadow_id[i] == id) slot = i;
      end
      hit = (slot < shadow_held);
      cnt = '0;
      st  = STATUS_OK;
      case (op)
         OP_LOOKUP: begin
            if (hit) cnt = shadow_count[slot];
            else st = STATUS_MISSING;
         end
         OP_REGISTER: begin
            if (hit) begin
               // count sticks at all ones
               if (shadow_count[slot] == COUNT_MAX) st = STATUS_SATURATED;
               else shadow_count[slot] = shadow_count[slot] + COUNT_ONE;
               cnt = shadow_count[slot];
            end else if (shadow_held >= ENTRIES) begin
               st = STATUS_FULL;
            end else begin
               // new id goes in at the head, older entries move down
               for (int i = shadow_held; i > 0; i--) begin
                  shadow_id[i]    = shadow_id[i-1];
                  shadow_count[i] = shadow_count[i-1];
               end
               shadow_id[0]    = id;
               shadow_count[0] = COUNT_ONE;
               shadow_held++;
               cnt = COUNT_ONE;
            end
         end
         OP_UNREGISTER: begin
            if (!hit) begin
               st = STATUS_MISSING;
            end else if (shadow_count[slot] > COUNT_ONE) begin
               shadow_count[slot] = shadow_count[slot] - COUNT_ONE;
               cnt = shadow_count[slot];
            end else begin
               // last reference gone: close the gap
               for (int i = slot; i + 1 < shadow_held; i++) begin
                  shadow_id[i]    = shadow_id[i+1];
                  shadow_count[i] = shadow_count[i+1];
               end
               shadow_held--;
               st = STATUS_REMOVED;
            end
         end
         default: shadow_held = 0;
      endcase
      r.found      = hit;
      r.position   = POS_W'(slot);
      r.ref_count  = REF_W'(cnt);
      r.item_count = ITEMS_W'(shadow_held);
      r.status     = st;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
      end
   endtask

   // compare the reply transaction first, then predict the request transaction
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         shadow_held = 0;
         awaited_replies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            replies_checked++;
            if (awaited_replies.size() == 0) begin
               mismatches++;
               $error("reply transaction with no request waiting");
            end else begin
               want = awaited_replies.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_mon.found));
               check_field("position", 32'(want.position), 32'(rsp_mon.position));
               check_field("ref_count", 32'(want.ref_count), 32'(rsp_mon.ref_count));
               check_field("item_count", 32'(want.item_count), 32'(rsp_mon.item_count));
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               if (want.status == STATUS_FULL) full_seen++;
               if (want.status == STATUS_SATURATED) saturated_seen++;
               if (want.status == STATUS_REMOVED) removed_seen++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_replies.push_back(apply_request(op_type'(req_mon.opcode), req_mon.id));
      end
      outstanding = awaited_replies.size();
   end

endmodule

// ===== verif/testbench.sv =====
// drives requests and reply backpressure into the id registry and gives the verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rcidr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic pace_on = 1'b1;

   int mismatches, outstanding, replies_checked;
   int full_seen, saturated_seen, removed_seen;
   int sent_by_op [4];

   logic [ID_W-1:0] id_pool [40];

   rcidr_req_if req_bus ();
   rcidr_rsp_if rsp_bus ();

   refcounted_id_registry_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   registry_reply_checker reply_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .replies_checked (replies_checked),
      .full_seen       (full_seen),
      .saturated_seen  (saturated_seen),
      .removed_seen    (removed_seen)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one request transaction, after an optional gap
   task automatic send(op_type op, logic [ID_W-1:0] id);
      int gap;
      gap = pace_on ? $urandom_range(0, 14) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.id     <= id;
      sent_by_op[op]++;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // stop sending until every reply is back, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (4) @(posedge clock);
   endtask

   // random traffic over a pool of ids, with some fully random ids as noise
   task automatic random_phase(int n, int pool_size, int clear_pct, int lookup_pct,
                               int unreg_pct);
      int          pick;
      logic [ID_W-1:0] id;
      op_type      op;
      for (int i = 0; i < pool_size; i++) id_pool[i] = $urandom;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 59) == 0) pace_on = ~pace_on;
         pick = $urandom_range(0, 99);
         if (pick < clear_pct) op = OP_CLEAR;
         else if (pick < clear_pct + lookup_pct) op = OP_LOOKUP;
         else if (pick < clear_pct + lookup_pct + unreg_pct) op = OP_UNREGISTER;
         else op = OP_REGISTER;
         if ($urandom_range(0, 9) == 0) id = $urandom;
         else id = id_pool[$urandom_range(0, pool_size - 1)];
         send(op, id);
      end
      pace_on = 1'b1;
      drain();
   endtask

   // reply side: stall a random number of cycles before each reply transaction
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = pace_on ? $urandom_range(0, 14) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // stimulus and verdict
   initial begin
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_LOOKUP;
      req_bus.id     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every operation, the corner cases
      send(OP_LOOKUP, 32'h0000_0000);
      send(OP_REGISTER, 32'h0000_0000);
      send(OP_REGISTER, 32'hFFFF_FFFF);
      send(OP_REGISTER, 32'h0000_0000);
      send(OP_LOOKUP, 32'h0000_0000);
      send(OP_UNREGISTER, 32'h0000_0000);
      send(OP_UNREGISTER, 32'hFFFF_FFFF);
      send(OP_UNREGISTER, 32'h1234_5678);
      for (int i = 1; i <= 15; i++) send(OP_REGISTER, 32'h8000_0000 | i);
      send(OP_REGISTER, 32'h7FFF_FFFF);
      send(OP_UNREGISTER, 32'h8000_0008);
      send(OP_LOOKUP, 32'h0000_0000);
      send(OP_CLEAR, 32'h8000_000F);
      send(OP_LOOKUP, 32'h8000_000F);
      drain();

      // repeated references to one id, back to back with no stalls
      pace_on = 1'b0;
      for (int i = 0; i < 6; i++) send(OP_REGISTER, 32'hA5C3_3C5A);
      send(OP_LOOKUP, 32'hA5C3_3C5A);
      for (int i = 0; i < 6; i++) send(OP_UNREGISTER, 32'hA5C3_3C5A);
      send(OP_LOOKUP, 32'hA5C3_3C5A);
      send(OP_REGISTER, 32'hA5C3_3C5A);
      send(OP_CLEAR, 32'h0000_0001);
      pace_on = 1'b1;
      drain();

      // random: small pool fills the table, larger pools churn it
      random_phase(520, 12, 2, 20, 25);
      random_phase(520, 24, 2, 20, 30);
      random_phase(510, 40, 3, 25, 35);

      $display("sent %0d lookups, %0d registers, %0d unregisters, %0d clears",
               sent_by_op[OP_LOOKUP], sent_by_op[OP_REGISTER],
               sent_by_op[OP_UNREGISTER], sent_by_op[OP_CLEAR]);
      $display("checked %0d replies: %0d table full, %0d saturated, %0d removals",
               replies_checked, full_seen, saturated_seen, removed_seen);
      if (mismatches == 0) begin
         $display("refcounted_id_registry_core test passed");
      end else begin
         $display("refcounted_id_registry_core test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("refcounted_id_registry_core test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rcidr_pkg.sv
hw/rtl/rcidr_if.sv
hw/rtl/rcidr_cell.sv
hw/rtl/refcounted_id_registry_core.sv
verif/registry_reply_checker.sv
verif/testbench.sv
